### hdl/isud_pkg.sv
// isud_pkg: shared types and constants for the interval set block
// no dependencies
package isud_pkg;
    localparam int MAX_BOUNDS_DEF = 64;
    localparam int POS_WIDTH_DEF  = 32;

    typedef enum logic [2:0] {
        OP_UNION = 3'd0,
        OP_DIFF  = 3'd1,
        OP_TEST  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_QUERY = 3'd4
    } t_opcode;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CAP  = 2'd1;
    localparam logic [1:0] ST_FORM = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SW_RD,
        S_SW_CMP,
        S_CP_RD,
        S_CP_WR,
        S_RP_RD,
        S_RP_ACC,
        S_RP_FIRST,
        S_OUT
    } t_state;
endpackage

### hdl/interval_set_union_difference.sv
// interval_set_union_difference: top level, sequencer and shared compare unit
// depends on isud_pkg and isud_ram
//
// Keeps a set of disjoint half-open intervals as a sorted start/end boundary
// list in a memory. Operand boundaries (opcode 0, 1 or 2) are taken one per
// cycle into an operand memory. The boundary marked last starts a merge walk
// (union, store minus operand, or overlap test only) if the operand is well
// formed. Each walk step, a read state then a compare state, consumes the
// store head, the operand head, or both when they sit at the same position. A
// run of operand boundaries at one position costs one step per boundary plus
// one more step before the position is written, unless the run ends the
// operand list. The walk ends when the read state sees both lists empty. A
// union or difference then copies the result back into the store, a read
// state and a write state per result boundary. Every result ends with a
// report pass over the store. Clear and query run only the report pass. The
// block takes no input while an operation is in progress. A finished result
// is held in an output register until transferred, so operand boundaries can
// be loaded meanwhile; the next result waits there until the held one is
// gone. Capacity overflow or a malformed operand leaves the store unchanged
// and is flagged in status. Unused opcodes are dropped silently.
module interval_set_union_difference
    import isud_pkg::*;
#(
    parameter int MAX_BOUNDS = MAX_BOUNDS_DEF,
    parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_position,
    input  logic        i_is_start,
    input  logic        i_last,
    input  logic [31:0] i_length_limit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_overlap,
    output logic [31:0] o_covered_length,
    output logic        o_first_valid,
    output logic [31:0] o_first_start,
    output logic [31:0] o_first_end,
    output logic [5:0]  o_segment_count
);
    localparam int AW = $clog2(MAX_BOUNDS);
    localparam int CW = $clog2(MAX_BOUNDS + 2);
    localparam int PW = POS_WIDTH;
    localparam logic [CW-1:0] CMAX = CW'(MAX_BOUNDS);

    t_state r_state, n_state;

    logic [CW-1:0] r_scount, n_scount;   // stored boundaries
    logic [CW-1:0] r_ocount, n_ocount;   // operand boundaries
    logic          r_oerr, n_oerr;
    logic [PW-1:0] r_olast, n_olast;     // last operand position
    logic [2:0]    r_op, n_op;
    logic [31:0]   r_limit, n_limit;

    // sweep state
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_n, n_n;
    logic          r_ins, n_ins, r_inop, n_inop, r_outcov, n_outcov, r_hit, n_hit;
    logic [PW-1:0] r_p, n_p;
    logic          r_have_p, n_have_p;

    // report accumulation
    logic [PW-1:0] r_sum, n_sum, r_prev, n_prev, r_fs, n_fs, r_fe, n_fe;

    // working status of the current operation
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_status, n_status;
    logic        r_overlap, n_overlap;

    // output register, parts the result from the next operation
    logic [1:0]  r_out_status, n_out_status;
    logic        r_out_overlap, n_out_overlap;
    logic [31:0] r_out_covered, n_out_covered;
    logic        r_out_fvalid, n_out_fvalid;
    logic [31:0] r_out_fstart, n_out_fstart, r_out_fend, n_out_fend;
    logic [5:0]  r_out_segs, n_out_segs;

    // memories
    logic          s_we, o_we, m_we;
    logic [AW-1:0] s_wa, o_wa, m_wa, s_ra, o_ra, m_ra;
    logic [PW-1:0] s_wd, o_wd, m_wd, s_rd, o_rd, m_rd;

    isud_ram #(.DEPTH(MAX_BOUNDS), .WIDTH(PW)) u_store (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    isud_ram #(.DEPTH(MAX_BOUNDS), .WIDTH(PW)) u_oper (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_wa), .i_wdata(o_wd),
        .i_raddr(o_ra), .o_rdata(o_rd));
    isud_ram #(.DEPTH(MAX_BOUNDS), .WIDTH(PW)) u_merge (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));

    logic [PW-1:0] pos_in;
    assign pos_in = PW'(i_position);

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scount <= '0;
            r_ocount <= '0;
            r_oerr   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scount <= n_scount;
            r_ocount <= n_ocount;
            r_oerr   <= n_oerr;
            r_ovalid <= n_ovalid;
        end
        r_olast <= n_olast;   r_op <= n_op;       r_limit <= n_limit;
        r_i <= n_i;           r_j <= n_j;         r_n <= n_n;
        r_ins <= n_ins;       r_inop <= n_inop;   r_outcov <= n_outcov;
        r_hit <= n_hit;       r_p <= n_p;         r_have_p <= n_have_p;
        r_sum <= n_sum;       r_prev <= n_prev;   r_fs <= n_fs;   r_fe <= n_fe;
        r_status <= n_status; r_overlap <= n_overlap;
        r_out_status <= n_out_status;   r_out_overlap <= n_out_overlap;
        r_out_covered <= n_out_covered; r_out_fvalid <= n_out_fvalid;
        r_out_fstart <= n_out_fstart;   r_out_fend <= n_out_fend;
        r_out_segs <= n_out_segs;
    end

    // sweep helpers
    logic iv, jv, take_s, take_o, cov, step_s, step_o;
    logic [PW-1:0] pmin, p_cur;
    logic [PW-1:0] len;

    always_comb begin
        n_state = r_state;   n_scount = r_scount; n_ocount = r_ocount;
        n_oerr = r_oerr;     n_olast = r_olast;   n_op = r_op;
        n_limit = r_limit;   n_i = r_i;           n_j = r_j;
        n_n = r_n;           n_ins = r_ins;       n_inop = r_inop;
        n_outcov = r_outcov; n_hit = r_hit;       n_p = r_p;
        n_have_p = r_have_p; n_sum = r_sum;       n_prev = r_prev;
        n_fs = r_fs;         n_fe = r_fe;         n_ovalid = r_ovalid;
        n_status = r_status; n_overlap = r_overlap;
        n_out_status = r_out_status;   n_out_overlap = r_out_overlap;
        n_out_covered = r_out_covered; n_out_fvalid = r_out_fvalid;
        n_out_fstart = r_out_fstart;   n_out_fend = r_out_fend;
        n_out_segs = r_out_segs;
        s_we = 1'b0; o_we = 1'b0; m_we = 1'b0;
        s_wa = '0; o_wa = '0; m_wa = '0;
        s_wd = '0; o_wd = pos_in; m_wd = r_p;
        s_ra = r_i[AW-1:0]; o_ra = r_j[AW-1:0]; m_ra = r_i[AW-1:0];
        iv = r_i < r_scount;
        jv = r_j < r_ocount;
        pmin = (iv && jv) ? ((s_rd < o_rd) ? s_rd : o_rd) : (iv ? s_rd : o_rd);
        take_s = iv && (s_rd == pmin);
        take_o = jv && (o_rd == pmin);
        step_s = 1'b0;
        step_o = 1'b0;
        p_cur = pmin;
        cov = 1'b0;
        len = s_rd - r_prev;

        if (o_valid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_limit = i_length_limit;
                    n_op    = i_opcode;
                    case (i_opcode)
                        OP_CLEAR: begin
                            n_scount = '0; n_ocount = '0; n_oerr = 1'b0;
                            n_status = ST_OK; n_overlap = 1'b0;
                            n_i = '0; n_state = S_RP_RD;
                        end
                        OP_QUERY: begin
                            n_status = ST_OK; n_overlap = 1'b0;
                            n_i = '0; n_state = S_RP_RD;
                        end
                        OP_UNION, OP_DIFF, OP_TEST: begin
                            if (r_ocount >= CMAX) begin
                                n_ocount = CMAX + CW'(1);
                            end else begin
                                if (i_is_start != ~r_ocount[0]) n_oerr = 1'b1;
                                if (r_ocount != '0 && pos_in < r_olast) n_oerr = 1'b1;
                                o_we = 1'b1;
                                o_wa = r_ocount[AW-1:0];
                                n_olast = pos_in;
                                n_ocount = r_ocount + CW'(1);
                            end
                            if (i_last) begin
                                n_overlap = 1'b0;
                                n_status  = ST_OK;
                                n_i = '0; n_j = '0; n_n = '0;
                                n_ins = 1'b0; n_inop = 1'b0;
                                n_outcov = 1'b0; n_hit = 1'b0;
                                n_have_p = 1'b0;
                                if (n_ocount > CMAX) begin
                                    n_status = ST_CAP;
                                end else if (n_oerr || n_ocount[0]) begin
                                    n_status = ST_FORM;
                                end
                                if (n_status != ST_OK) begin
                                    n_ocount = '0; n_oerr = 1'b0;
                                    n_state = S_RP_RD;
                                end else begin
                                    n_state = S_SW_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // read heads of both lists
            S_SW_RD: begin
                if (!iv && !jv) begin
                    n_ocount = '0; n_oerr = 1'b0;
                    if (r_op == OP_TEST) begin
                        n_overlap = r_hit;
                        n_i = '0; n_state = S_RP_RD;
                    end else if (r_n > CMAX) begin
                        n_status = ST_CAP;
                        n_i = '0; n_state = S_RP_RD;
                    end else begin
                        n_i = '0; n_state = S_CP_RD;
                    end
                end else begin
                    n_state = S_SW_CMP;
                end
            end
            // one compare step: consume store head, operand head at min
            S_SW_CMP: begin
                if (r_have_p) begin
                    // still at the held position: only operand repeats
                    step_o = jv && (o_rd == r_p);
                    p_cur  = r_p;
                end else begin
                    step_s = take_s;
                    step_o = take_o;
                end
                if (step_s) begin
                    n_ins = ~r_i[0];
                    n_i = r_i + CW'(1);
                end
                if (step_o) begin
                    n_inop = ~r_j[0];
                    n_j = r_j + CW'(1);
                end
                n_p = p_cur;
                n_have_p = 1'b0;
                if (step_o && (r_j + CW'(1) < r_ocount)) begin
                    // operand may repeat this position: look again before writing
                    n_have_p = 1'b1;
                end else begin
                    if (n_ins && n_inop) n_hit = 1'b1;
                    case (r_op)
                        OP_UNION: cov = n_ins || n_inop;
                        OP_DIFF:  cov = n_ins && !n_inop;
                        default:  cov = n_ins;
                    endcase
                    if (cov != r_outcov) begin
                        if (r_n < CMAX) begin
                            m_we = 1'b1;
                            m_wa = r_n[AW-1:0];
                            m_wd = p_cur;
                        end
                        if (r_n <= CMAX) n_n = r_n + CW'(1);
                        n_outcov = cov;
                    end
                end
                n_state = S_SW_RD;
            end
            S_CP_RD: begin
                if (r_i >= r_n) begin
                    n_scount = r_n;
                    n_i = '0; n_state = S_RP_RD;
                end else begin
                    n_state = S_CP_WR;
                end
            end
            S_CP_WR: begin
                s_we = 1'b1;
                s_wa = r_i[AW-1:0];
                s_wd = m_rd;
                n_i = r_i + CW'(1);
                n_state = S_CP_RD;
            end
            S_RP_RD: begin
                if (r_i == '0) n_sum = '0;
                if (r_i + CW'(1) >= r_scount + CW'(1) || r_i >= (r_scount & ~CW'(1))) begin
                    n_state = S_RP_FIRST;
                    n_i = '0;
                end else begin
                    n_state = S_RP_ACC;
                end
            end
            S_RP_ACC: begin
                if (!r_i[0]) begin
                    n_prev = s_rd;
                    if (r_i == '0) n_fs = s_rd;
                end else begin
                    n_sum = r_sum + len;
                    if (r_i == CW'(1)) n_fe = s_rd;
                end
                n_i = r_i + CW'(1);
                n_state = S_RP_RD;
            end
            S_RP_FIRST: begin
                if (r_scount < CW'(2)) begin
                    n_fs = '0; n_fe = '0;
                end else if (64'(r_fe - r_fs) > 64'(r_limit)) begin
                    n_fe = r_fs + PW'(r_limit);
                end
                n_state = S_OUT;
            end
            // load the output register once the held result is gone
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_out_status  = r_status;
                    n_out_overlap = r_overlap;
                    n_out_covered = 32'(r_sum);
                    n_out_fvalid  = r_scount >= CW'(2);
                    n_out_fstart  = 32'(r_fs);
                    n_out_fend    = 32'(r_fe);
                    n_out_segs    = 6'(r_scount >> 1);
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_out_status;
    assign o_overlap        = r_out_overlap;
    assign o_covered_length = r_out_covered;
    assign o_first_valid    = r_out_fvalid;
    assign o_first_start    = r_out_fstart;
    assign o_first_end      = r_out_fend;
    assign o_segment_count  = r_out_segs;
endmodule

### hdl/isud_ram.sv
// isud_ram: one-write, one-read boundary memory with registered read data
// depends on isud_pkg
module isud_ram
    import isud_pkg::*;
#(
    parameter int DEPTH = MAX_BOUNDS_DEF,
    parameter int WIDTH = POS_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### tb/interval_set_union_difference_tb.sv
`timescale 1ns / 100ps
// interval_set_union_difference_tb: self-checking bench for the interval set block
// depends on isud_pkg and the interval_set_union_difference rtl
module interval_set_union_difference_tb
    import isud_pkg::*;
();

    localparam int NB = 64;
    localparam int WD_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_opcode;
    logic [31:0] i_position;
    logic        i_is_start;
    logic        i_last;
    logic [31:0] i_length_limit;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic        o_overlap;
    logic [31:0] o_covered_length;
    logic        o_first_valid;
    logic [31:0] o_first_start;
    logic [31:0] o_first_end;
    logic [5:0]  o_segment_count;

    interval_set_union_difference i_dut (.*);

    // one input item and one result item
    typedef struct {
        logic [2:0]  opcode;
        logic [31:0] position;
        logic        is_start;
        logic        last;
        logic [31:0] length_limit;
    } t_item;

    typedef struct {
        logic [1:0]  status;
        logic        overlap;
        logic [31:0] covered;
        logic        fvalid;
        logic [31:0] fstart;
        logic [31:0] fend;
        logic [5:0]  segs;
    } t_summary;

    // directed row: expected summary typed in only where obvious
    typedef struct {
        t_item    it;
        bit       fixed;
        t_summary want;
    } t_row;

    // predictor state: store and partly loaded operand
    logic [31:0] set_bnd[NB];
    int          set_cnt;
    logic [31:0] opd_bnd[NB];
    int          opd_cnt;
    bit          opd_bad;

    t_summary pending_q[$];
    t_item    send_q[$];
    int       n_err = 0;
    int       n_results = 0;
    int       n_items = 0;
    int       idle_cycles = 0;
    int       hold_req = 0;
    int       hold_len = 300;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_summary summarize(logic [1:0] st, bit ov, logic [31:0] lim);
        t_summary s;
        logic [31:0] acc;
        acc = 32'd0;
        for (int k = 0; k + 1 < set_cnt; k += 2) acc += set_bnd[k+1] - set_bnd[k];
        s.status = st; s.overlap = ov; s.covered = acc;
        s.fvalid = set_cnt >= 2;
        s.fstart = 32'd0; s.fend = 32'd0;
        if (set_cnt >= 2) begin
            s.fstart = set_bnd[0];
            s.fend = (set_bnd[1] - set_bnd[0] > lim) ? set_bnd[0] + lim : set_bnd[1];
        end
        s.segs = 6'(set_cnt / 2);
        return s;
    endfunction

    // apply one item to the predictor; returns 1 if a summary is produced
    function automatic bit apply_item(t_item it, output t_summary s);
        logic [31:0] mrg[NB];
        int i, j, n;
        bit ins, inop, outc, cov, hit;
        logic [31:0] p;
        logic [1:0] st;
        bit ov;
        st = ST_OK; ov = 1'b0;
        if (it.opcode == OP_CLEAR) begin
            set_cnt = 0; opd_cnt = 0; opd_bad = 1'b0;
            s = summarize(ST_OK, 1'b0, it.length_limit);
            return 1'b1;
        end
        if (it.opcode == OP_QUERY) begin
            s = summarize(ST_OK, 1'b0, it.length_limit);
            return 1'b1;
        end
        if (it.opcode > OP_QUERY) return 1'b0;
        if (opd_cnt >= NB) opd_cnt = NB + 1;
        else begin
            if (it.is_start != (opd_cnt % 2 == 0)) opd_bad = 1'b1;
            if (opd_cnt > 0 && it.position < opd_bnd[opd_cnt-1]) opd_bad = 1'b1;
            opd_bnd[opd_cnt] = it.position;
            opd_cnt++;
        end
        if (!it.last) return 1'b0;
        if (opd_cnt > NB) st = ST_CAP;
        else if (opd_bad || opd_cnt % 2) st = ST_FORM;
        else begin
            i = 0; j = 0; n = 0;
            ins = 1'b0; inop = 1'b0; outc = 1'b0; hit = 1'b0;
            while (i < set_cnt || j < opd_cnt) begin
                if (i < set_cnt && j < opd_cnt)
                    p = set_bnd[i] < opd_bnd[j] ? set_bnd[i] : opd_bnd[j];
                else if (i < set_cnt) p = set_bnd[i];
                else p = opd_bnd[j];
                if (i < set_cnt && set_bnd[i] == p) begin
                    ins = (i % 2 == 0); i++;
                end
                while (j < opd_cnt && opd_bnd[j] == p) begin
                    inop = (j % 2 == 0); j++;
                end
                if (ins && inop) hit = 1'b1;
                if (it.opcode == OP_UNION) cov = ins || inop;
                else if (it.opcode == OP_DIFF) cov = ins && !inop;
                else cov = ins;
                if (cov != outc) begin
                    if (n < NB) mrg[n] = p;
                    n++; outc = cov;
                end
            end
            if (it.opcode == OP_TEST) ov = hit;
            else if (n > NB) st = ST_CAP;
            else begin
                for (int k = 0; k < n; k++) set_bnd[k] = mrg[k];
                set_cnt = n;
            end
        end
        opd_cnt = 0; opd_bad = 1'b0;
        s = summarize(st, ov, it.length_limit);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch result %0d %s: got %h want %h", n_results, what, got, want);
        n_err++;
    endtask

    function automatic t_item mk(logic [2:0] op, logic [31:0] pos, bit st, bit lst,
                                 logic [31:0] lim = 32'hffff_ffff);
        t_item it;
        it.opcode = op; it.position = pos; it.is_start = st; it.last = lst;
        it.length_limit = lim;
        return it;
    endfunction

    // queue an item; predictor runs at send time, order of acceptance matches
    task automatic push_item(t_item it);
        t_summary s;
        if (apply_item(it, s)) pending_q.push_back(s);
        send_q.push_back(it);
    endtask

    // well-formed operand with random content; mostly small values
    task automatic push_operand(logic [2:0] op, int nb);
        logic [31:0] pos;
        logic [31:0] lim;
        pos = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
        lim = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 50);
        for (int k = 0; k < nb; k++) begin
            if (k > 0) pos = (pos > 32'hffff_ff00) ? pos : pos + $urandom_range(0, 40);
            push_item(mk(op, pos, (k % 2) == 0, k == nb - 1, lim));
        end
    endtask

    // sender: waits a random gap, then offers the next item
    task automatic send_all();
        t_item it;
        int gap;
        while (send_q.size() > 0) begin
            it = send_q.pop_front();
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17));
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1; i_opcode <= it.opcode; i_position <= it.position;
            i_is_start <= it.is_start; i_last <= it.last;
            i_length_limit <= it.length_limit;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            n_items++;
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // receiver: random stall per result, long hold when asked
    initial begin
        int w;
        int seen;
        seen = 0;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req != seen) begin
                seen = hold_req;
                i_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17));
            if (w > 0) begin
                i_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_summary e;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $display("unexpected result %0d", n_results);
                n_err++;
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status)
                    report_mismatch("status", 32'(o_status), 32'(e.status));
                if (o_overlap !== e.overlap)
                    report_mismatch("overlap", 32'(o_overlap), 32'(e.overlap));
                if (o_covered_length !== e.covered)
                    report_mismatch("covered", o_covered_length, e.covered);
                if (o_first_valid !== e.fvalid)
                    report_mismatch("first_valid", 32'(o_first_valid), 32'(e.fvalid));
                if (o_first_start !== e.fstart)
                    report_mismatch("first_start", o_first_start, e.fstart);
                if (o_first_end !== e.fend) report_mismatch("first_end", o_first_end, e.fend);
                if (o_segment_count !== e.segs)
                    report_mismatch("segments", 32'(o_segment_count), 32'(e.segs));
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_summary s, zero;
        int nb;
        set_cnt = 0; opd_cnt = 0; opd_bad = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_opcode = OP_QUERY; i_position = 32'd0;
        i_is_start = 1'b0; i_last = 1'b0; i_length_limit = 32'd0;
        zero = '{ST_OK, 1'b0, 32'd0, 1'b0, 32'd0, 32'd0, 6'd0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        r.fixed = 1'b1; r.want = zero;
        r.it = mk(OP_QUERY, 0, 1'b0, 1'b0, 0); rows.push_back(r);      // empty after reset
        r.it = mk(OP_UNION, 32'hffff_ffff, 1'b1, 1'b1); r.want.status = ST_FORM;
        rows.push_back(r);                                             // odd count
        r.it = mk(OP_UNION, 0, 1'b0, 1'b0); r.fixed = 1'b0;
        rows.push_back(r);                                             // starts with end
        r.it = mk(OP_UNION, 10, 1'b1, 1'b1); r.fixed = 1'b1; rows.push_back(r);
        r.fixed = 1'b0;
        r.it = mk(OP_UNION, 0, 1'b1, 1'b0); rows.push_back(r);         // full span
        r.it = mk(OP_UNION, 32'hffff_ffff, 1'b0, 1'b1, 32'h10); rows.push_back(r);
        r.it = mk(OP_DIFF, 100, 1'b1, 1'b0); rows.push_back(r);
        r.it = mk(OP_DIFF, 100, 1'b0, 1'b1); rows.push_back(r);        // empty operand piece
        r.it = mk(OP_DIFF, 20, 1'b1, 1'b0); rows.push_back(r);
        r.it = mk(OP_DIFF, 40, 1'b0, 1'b1, 5); rows.push_back(r);
        r.it = mk(OP_TEST, 30, 1'b1, 1'b0); rows.push_back(r);
        r.it = mk(OP_TEST, 45, 1'b0, 1'b1); rows.push_back(r);         // overlap hit
        r.it = mk(OP_TEST, 20, 1'b1, 1'b0); rows.push_back(r);
        r.it = mk(OP_TEST, 40, 1'b0, 1'b1); rows.push_back(r);         // no overlap
        r.it = mk(OP_UNION, 50, 1'b1, 1'b0); rows.push_back(r);
        r.it = mk(OP_UNION, 40, 1'b0, 1'b1); rows.push_back(r);        // descending
        r.it = mk(3'd5, 7, 1'b1, 1'b1); rows.push_back(r);             // unused opcodes
        r.it = mk(3'd7, 7, 1'b0, 1'b1); rows.push_back(r);
        r.it = mk(OP_UNION, 5, 1'b1, 1'b0); rows.push_back(r);         // left partly loaded
        r.it = mk(OP_QUERY, 0, 1'b0, 1'b0, 0); rows.push_back(r);
        r.it = mk(OP_QUERY, 0, 1'b0, 1'b0, 32'hffff_ffff); rows.push_back(r);
        r.it = mk(OP_CLEAR, 0, 1'b0, 1'b0); r.fixed = 1'b1; r.want = zero;
        rows.push_back(r);
        foreach (rows[k]) begin
            if (rows[k].fixed) begin
                void'(apply_item(rows[k].it, s));
                pending_q.push_back(rows[k].want);
                send_q.push_back(rows[k].it);
            end else push_item(rows[k].it);
        end
        send_all();
        drain();

        // operand overflow, then a result too long for the store
        for (int k = 0; k < NB + 2; k++)
            push_item(mk(OP_UNION, k * 3, (k % 2) == 0, k == NB + 1));
        for (int k = 0; k < NB; k++)
            push_item(mk(OP_UNION, k * 4, (k % 2) == 0, k == NB - 1));
        push_item(mk(OP_UNION, 1, 1'b1, 1'b0));
        push_item(mk(OP_UNION, 2, 1'b0, 1'b1));
        push_item(mk(OP_DIFF, 1, 1'b1, 1'b0));
        push_item(mk(OP_DIFF, 2, 1'b0, 1'b1));
        push_item(mk(OP_DIFF, 5, 1'b1, 1'b0));
        push_item(mk(OP_DIFF, 6, 1'b0, 1'b1));                         // lies in a gap: no change
        push_item(mk(OP_CLEAR, 0, 1'b0, 1'b0));
        send_all();
        drain();

        // receiver holds off while queries keep coming
        hold_req++;
        for (int k = 0; k < 12; k++) push_item(mk(OP_QUERY, 0, 1'b0, 1'b0, $urandom));
        send_all();
        drain();

        // random part: mostly well-formed operands, some noise
        while (n_items < 420) begin
            for (int g = 0; g < 8; g++) begin
                case ($urandom_range(0, 9))
                    0: push_item(mk(OP_CLEAR, $urandom, 1'($urandom), 1'($urandom),
                                    $urandom));
                    1: push_item(mk(OP_QUERY, $urandom, 1'($urandom), 1'($urandom),
                                    $urandom));
                    2: push_item(mk(3'($urandom_range(0, 7)), $urandom, 1'($urandom),
                                    1'($urandom), $urandom));
                    default: begin
                        nb = 2 * int'($urandom_range(1, 4));
                        push_operand(3'($urandom_range(0, 2)), nb);
                    end
                endcase
            end
            send_all();
            if ($urandom_range(0, 4) == 0) drain();
        end
        push_item(mk(OP_QUERY, 0, 1'b0, 1'b0, $urandom));
        send_all();
        drain();

        $display("%0d items sent, %0d results checked: union, difference, overlap test,",
                 n_items, n_results);
        $display("clear, query, malformed and overflowing operands, long output stall");
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
